// ----- hw/rtl/otun_pkg.sv -----
// Shared types and constants for the oriented triangle unit normal block.
package otun_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned EdgeW  = CoordW + 1;
  localparam int unsigned InW    = 11 * CoordW;
  localparam int unsigned OutW   = 128;
  localparam int unsigned CountW = 31;

  // Edge vectors of one selected triangle, after any vertex exchange.
  typedef struct packed {
    logic [2:0][EdgeW-1:0] u;
    logic [2:0][EdgeW-1:0] w;
    logic                  swap;
  } tri_t;

endpackage

// ----- hw/rtl/otun_front.sv -----
// Front end: label match, vertex exchange and edge vectors.
module otun_front import otun_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [InW-1:0]  in_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [31:0]     target_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output tri_t            q_data_o
);

  logic [2:0][CoordW-1:0] v1, v2, v3;
  logic                   front_hit, back_hit;

  assign front_hit = in_data_i[9*CoordW +: CoordW] == target_i;
  assign back_hit  = in_data_i[10*CoordW +: CoordW] == target_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v1[i] = in_data_i[i*CoordW +: CoordW];
      v2[i] = front_hit ? in_data_i[(3+i)*CoordW +: CoordW] : in_data_i[(6+i)*CoordW +: CoordW];
      v3[i] = front_hit ? in_data_i[(6+i)*CoordW +: CoordW] : in_data_i[(3+i)*CoordW +: CoordW];
      q_data_o.u[i] = EdgeW'($signed({v2[i][CoordW-1], v2[i]}) -
                             $signed({v1[i][CoordW-1], v1[i]}));
      q_data_o.w[i] = EdgeW'($signed({v3[i][CoordW-1], v3[i]}) -
                             $signed({v1[i][CoordW-1], v1[i]}));
    end
    q_data_o.swap = !front_hit;
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && in_ready_o && (front_hit || back_hit);

endmodule

// ----- hw/rtl/otun_fifo.sv -----
// Two-entry queue between the front end and the back end.
module otun_fifo import otun_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  tri_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output tri_t data_o
);

  tri_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop_i) rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ----- hw/rtl/otun_back.sv -----
// Back end: cross product, normalization, square root, divisions and output.
module otun_back import otun_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  tri_t              q_data_i,
  output logic              q_pop_o,
  input  logic              cnt_clear_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [OutW-1:0]   out_data_o,
  output logic [1:0]        out_user_o
);

  typedef enum logic [2:0] {
    StIdle, StMul, StAbs, StNorm, StSqr, StSqrt, StDiv, StDone
  } state_e;

  state_e                 state_q;
  logic [4:0]             step_q;
  tri_t                   tri_q;
  logic signed [65:0]     prod_q;
  logic [1:0]             pidx_q;
  logic                   psub_q;
  logic signed [66:0]     c_q [3];
  logic [65:0]            m_q [3];
  logic [2:0]             neg_q;
  logic                   degen_q;
  logic [61:0]            sq_q;
  logic [63:0]            sum_q, res_q, bit_q;
  logic [31:0]            len_q;
  logic [31:0]            r_q [3];
  logic [30:0]            dsh_q [3];
  logic [30:0]            quo_q [3];
  logic [CountW-1:0]      cnt_q;

  logic signed [32:0]     mul_a, mul_b;
  logic [1:0]             mul_idx;
  logic                   mul_sub;
  logic [65:0]            m_or;
  logic [30:0]            s_sel;
  logic [63:0]            sq_try;
  logic [61:0]            dvd [3];
  logic [32:0]            r2 [3];
  logic [CountW-1:0]      cnt_next;
  logic [2:0][31:0]       nrm;
  logic                   out_load;

  // Cross product terms in issue order; odd steps subtract.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_idx = 2'd0;
    mul_sub = step_q[0];
    unique case (step_q[2:0])
      3'd0: begin mul_a = tri_q.u[1]; mul_b = tri_q.w[2]; mul_idx = 2'd0; end
      3'd1: begin mul_a = tri_q.u[2]; mul_b = tri_q.w[1]; mul_idx = 2'd0; end
      3'd2: begin mul_a = tri_q.u[2]; mul_b = tri_q.w[0]; mul_idx = 2'd1; end
      3'd3: begin mul_a = tri_q.u[0]; mul_b = tri_q.w[2]; mul_idx = 2'd1; end
      3'd4: begin mul_a = tri_q.u[0]; mul_b = tri_q.w[1]; mul_idx = 2'd2; end
      3'd5: begin mul_a = tri_q.u[1]; mul_b = tri_q.w[0]; mul_idx = 2'd2; end
      default: begin mul_a = '0; mul_b = '0; mul_idx = 2'd0; end
    endcase
  end

  assign m_or   = m_q[0] | m_q[1] | m_q[2];
  assign s_sel  = (step_q[1:0] == 2'd0) ? m_q[0][30:0] :
                  (step_q[1:0] == 2'd1) ? m_q[1][30:0] : m_q[2][30:0];
  assign sq_try = res_q + bit_q;
  assign cnt_next = (cnt_q == {CountW{1'b1}}) ? cnt_q : cnt_q + 1'b1;
  assign out_load = (state_q == StDone) && (!out_valid_o || out_ready_i);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dvd[i] = {1'b0, m_q[i][30:0], 30'd0} + 62'(len_q[31:1]);
      r2[i]  = {r_q[i], dsh_q[i][30]};
      nrm[i] = neg_q[i] ? 32'd0 - {1'b0, quo_q[i]} : {1'b0, quo_q[i]};
      if (degen_q) nrm[i] = 32'd0;
    end
  end

  assign q_pop_o = (state_q == StIdle) && !q_empty_i;

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: tri_q <= q_data_i;
      StMul: begin
        prod_q <= mul_a * mul_b;
        pidx_q <= mul_idx;
        psub_q <= mul_sub;
        if (step_q == 5'd0) begin
          for (int i = 0; i < 3; i++) c_q[i] <= '0;
        end else if (psub_q) begin
          c_q[pidx_q] <= c_q[pidx_q] - 67'(prod_q);
        end else begin
          c_q[pidx_q] <= c_q[pidx_q] + 67'(prod_q);
        end
      end
      StAbs: begin
        for (int i = 0; i < 3; i++) begin
          neg_q[i] <= c_q[i][66];
          m_q[i]   <= c_q[i][66] ? 66'(-c_q[i]) : 66'(c_q[i]);
        end
      end
      StNorm: begin
        // Common shift toward [2^30, 2^31), eight bits or one bit a cycle.
        for (int i = 0; i < 3; i++) begin
          priority if (|m_or[65:39]) m_q[i] <= m_q[i] >> 8;
          else if (|m_or[65:31])     m_q[i] <= m_q[i] >> 1;
          else if (!(|m_or[30:22]))  m_q[i] <= m_q[i] << 8;
          else if (!m_or[30])        m_q[i] <= m_q[i] << 1;
          else                       m_q[i] <= m_q[i];
        end
        sum_q <= '0;
      end
      StSqr: begin
        sq_q <= s_sel * s_sel;
        if (step_q != 5'd0) sum_q <= sum_q + 64'(sq_q);
        res_q <= '0;
        bit_q <= 64'd1 << 62;
      end
      StSqrt: begin
        if (sum_q >= sq_try) begin
          sum_q <= sum_q - sq_try;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (step_q == 5'd31) len_q <= (sum_q >= sq_try) ? 32'((res_q >> 1) + bit_q)
                                                         : 32'(res_q >> 1);
        if (step_q == 5'd31) begin
          for (int i = 0; i < 3; i++) quo_q[i] <= '0;
        end
      end
      default: ;
    endcase

    // Division lanes: loaded on entry, one quotient bit per cycle after.
    if (state_q == StSqrt && step_q == 5'd31) begin
      for (int i = 0; i < 3; i++) r_q[i] <= '0;
    end
    if (state_q == StDiv) begin
      for (int i = 0; i < 3; i++) begin
        if (step_q == 5'd0) begin
          r_q[i]   <= {1'b0, dvd[i][61:31]};
          dsh_q[i] <= dvd[i][30:0];
          quo_q[i] <= '0;
        end else if (r2[i] >= {1'b0, len_q}) begin
          r_q[i]   <= 32'(r2[i] - {1'b0, len_q});
          dsh_q[i] <= dsh_q[i] << 1;
          quo_q[i] <= {quo_q[i][29:0], 1'b1};
        end else begin
          r_q[i]   <= r2[i][31:0];
          dsh_q[i] <= dsh_q[i] << 1;
          quo_q[i] <= {quo_q[i][29:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      degen_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_o <= 1'b0;
      out_data_o  <= '0;
      out_user_o  <= '0;
    end else begin
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (cnt_clear_i) begin
        cnt_q <= '0;
      end else if (out_load) begin
        cnt_q <= cnt_next;
      end
      unique case (state_q)
        StIdle: begin
          step_q <= '0;
          if (!q_empty_i) state_q <= StMul;
        end
        StMul: begin
          if (step_q == 5'd6) begin
            step_q  <= '0;
            state_q <= StAbs;
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        StAbs: begin
          degen_q <= (c_q[0] == '0) && (c_q[1] == '0) && (c_q[2] == '0);
          state_q <= ((c_q[0] == '0) && (c_q[1] == '0) && (c_q[2] == '0)) ? StDone
                                                                            : StNorm;
        end
        StNorm: begin
          if (!(|m_or[65:31]) && m_or[30]) begin
            step_q  <= '0;
            state_q <= StSqr;
          end
        end
        StSqr: begin
          if (step_q == 5'd3) begin
            step_q  <= '0;
            state_q <= StSqrt;
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        StSqrt: begin
          step_q <= step_q + 5'd1;
          if (step_q == 5'd31) state_q <= StDiv;
        end
        StDiv: begin
          step_q <= step_q + 5'd1;
          if (step_q == 5'd31) state_q <= StDone;
        end
        StDone: begin
          if (out_load) begin
            out_data_o  <= {1'b0, cnt_next, nrm[2], nrm[1], nrm[0]};
            out_user_o  <= {degen_q, tri_q.swap};
            degen_q     <= 1'b0;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ----- hw/rtl/oriented_triangle_unit_normal_top.sv -----
// Top level of the oriented triangle unit normal block.
// Usage: triangles arrive on the s_axis word channel, one per word, with the
// nine Q16.16 vertex coordinates and the front and back feature labels. A
// triangle whose front label equals the target feature is kept as given; one
// whose back label alone matches has its second and third vertices
// exchanged; any other triangle is dropped and gives no result word. Kept
// triangles leave on the m_axis channel as a Q2.30 unit normal, the running
// kept count and the swapped and degenerate flags.
// The front end classifies a triangle and forms its edge vectors in the
// cycle it is accepted, then parks it in a two-entry queue. The back end
// works on one triangle at a time, which sets the throughput: it pops it,
// builds the cross product with the shared multiplier, takes the
// magnitudes, normalizes them, sums the squares, runs the bit-pair square
// root and three parallel restoring dividers and loads the result word. A
// degenerate triangle skips the steps from normalization to the dividers.
// Reset clears the target feature, the kept count, the queue and the output
// register. When the receiver stalls, the result word holds, the back end
// waits with the next result, and the queue fills before s_axis_tready drops.
// The target register sits at APB address 0; writing it clears the count.
module oriented_triangle_unit_normal_top import otun_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // ax, ay, az, bx, by_coord, bz, cx, cy, cz, front_label, back_label
  input  logic [InW-1:0]   s_axis_tdata,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // nx, ny, nz, kept_count, one zero pad bit
  output logic [OutW-1:0]  m_axis_tdata,
  // swapped, degenerate
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [31:0] target_q;
  logic        cfg_wr;
  logic        q_push, q_full, q_pop, q_empty;
  tri_t        q_in, q_out;

  assign pready = 1'b1;
  // Only register 0 exists; the low byte-lane bits are ignored.
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_wr) begin
      target_q <= pwdata;
    end
  end

  otun_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .target_i   (target_q),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  otun_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_out)
  );

  otun_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_out),
    .q_pop_o     (q_pop),
    .cnt_clear_i (cfg_wr),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

`ifndef SYNTHESIS
  // A degenerate result carries a zero normal.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[95:0] == '0)
    else $error("degenerate result with nonzero normal");

  // Every result counts at least itself.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[126:96] != '0)
    else $error("result with zero kept count");

  // The queue is never pushed while full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_push)
    else $error("queue overflow");
`endif

endmodule

// ----- test/otun_checker.sv -----
// Checker that predicts and compares result words of the triangle normal block.
module otun_checker import otun_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [InW-1:0]  s_tdata,
  input  logic            s_tvalid,
  input  logic            s_tready,
  input  logic [OutW-1:0] m_tdata,
  input  logic [1:0]      m_tuser,
  input  logic            m_tvalid,
  input  logic            m_tready,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output int              fail_count,
  output int              pending_normals,
  output int              kept_seen,
  output int              swap_seen,
  output int              degen_seen
);

  typedef struct packed {
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] nz;
    logic [30:0] cnt;
    logic        swp;
    logic        dgn;
  } normal_t;

  normal_t     normal_q[$];
  logic [31:0] sel_feature;
  logic [30:0] kept_run;

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Computes the unit normal for a kept triangle; count is handled outside.
  function automatic normal_t face_normal(input logic [InW-1:0] d, input logic swp);
    logic signed [33:0]  p1 [3];
    logic signed [33:0]  p2 [3];
    logic signed [33:0]  p3 [3];
    logic signed [33:0]  u [3];
    logic signed [33:0]  w [3];
    logic signed [69:0]  c [3];
    logic        [69:0]  mg [3];
    logic        [63:0]  s [3];
    logic        [63:0]  sum, len, q;
    logic        [31:0]  outc [3];
    int                  bl, k, j;
    normal_t             r;
    for (int i = 0; i < 3; i++) begin
      p1[i] = 34'(signed'(d[32*i +: 32]));
      p2[i] = 34'(signed'(d[32*(swp ? 6+i : 3+i) +: 32]));
      p3[i] = 34'(signed'(d[32*(swp ? 3+i : 6+i) +: 32]));
      u[i]  = p2[i] - p1[i];
      w[i]  = p3[i] - p1[i];
    end
    c[0] = 70'(u[1]) * 70'(w[2]) - 70'(u[2]) * 70'(w[1]);
    c[1] = 70'(u[2]) * 70'(w[0]) - 70'(u[0]) * 70'(w[2]);
    c[2] = 70'(u[0]) * 70'(w[1]) - 70'(u[1]) * 70'(w[0]);
    bl = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = c[i] < 0 ? 70'(-c[i]) : 70'(c[i]);
      for (j = 69; j >= 0; j--) if (mg[i][j]) break;
      if (j + 1 > bl) bl = j + 1;
    end
    r     = '0;
    r.swp = swp;
    r.dgn = (bl == 0);
    if (bl != 0) begin
      k   = bl - 31;
      sum = '0;
      for (int i = 0; i < 3; i++) begin
        s[i] = k >= 0 ? 64'(mg[i] >> k) : 64'(mg[i] << (-k));
        sum  = sum + s[i] * s[i];
      end
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
        q       = ((s[i] << 30) + (len >> 1)) / len;
        outc[i] = c[i] < 0 ? 32'(-q) : 32'(q);
      end
      r.nx = outc[0];
      r.ny = outc[1];
      r.nz = outc[2];
    end
    return r;
  endfunction

  assign pending_normals = normal_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    normal_t e, got;
    logic    hit_f, hit_b;
    if (!rst_ni) begin
      sel_feature <= '0;
      kept_run    <= '0;
      fail_count  <= 0;
      kept_seen   <= 0;
      swap_seen   <= 0;
      degen_seen  <= 0;
      normal_q.delete();
    end else begin
      if (psel && penable && pwrite && !paddr[2]) begin
        sel_feature <= pwdata;
        kept_run    <= '0;
      end
      if (s_tvalid && s_tready) begin
        hit_f = s_tdata[32*9 +: 32] == sel_feature;
        hit_b = s_tdata[32*10 +: 32] == sel_feature;
        if (hit_f || hit_b) begin
          e     = face_normal(s_tdata, !hit_f);
          e.cnt = kept_run == 31'h7FFFFFFF ? kept_run : kept_run + 31'd1;
          kept_run <= e.cnt;
          normal_q.insert(normal_q.size(), e);
        end
      end
      if (m_tvalid && m_tready) begin
        got.nx  = m_tdata[31:0];
        got.ny  = m_tdata[63:32];
        got.nz  = m_tdata[95:64];
        got.cnt = m_tdata[126:96];
        got.swp = m_tuser[0];
        got.dgn = m_tuser[1];
        if (normal_q.size() == 0) begin
          $error("result word with no expectation waiting");
          fail_count <= fail_count + 1;
        end else begin
          e = normal_q.pop_front();
          kept_seen  <= kept_seen + 1;
          swap_seen  <= swap_seen + int'(got.swp);
          degen_seen <= degen_seen + int'(got.dgn);
          if (got != e) begin
            fail_count <= fail_count + 1;
            if (got.nx != e.nx) $error("nx: expected %h actual %h", e.nx, got.nx);
            if (got.ny != e.ny) $error("ny: expected %h actual %h", e.ny, got.ny);
            if (got.nz != e.nz) $error("nz: expected %h actual %h", e.nz, got.nz);
            if (got.cnt != e.cnt)
              $error("kept_count: expected %0d actual %0d", e.cnt, got.cnt);
            if (got.swp != e.swp)
              $error("swapped: expected %0d actual %0d", e.swp, got.swp);
            if (got.dgn != e.dgn)
              $error("degenerate: expected %0d actual %0d", e.dgn, got.dgn);
          end
        end
      end
    end
  end

endmodule

// ----- test/oriented_triangle_unit_normal_top_tb.sv -----
// Stimulus and verdict for the oriented triangle unit normal block.
module oriented_triangle_unit_normal_top_tb;
  import otun_pkg::*;

  // Settle time that drain() waits after the last expected result.
  localparam int DrainCycles = 200;

  logic            clk_i;
  logic            rst_ni;
  logic [InW-1:0]  s_axis_tdata;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [OutW-1:0] m_axis_tdata;
  logic [1:0]      m_axis_tuser;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic            psel, penable, pwrite, pready;
  logic [2:0]      paddr;
  logic [31:0]     pwdata, prdata;
  int              fail_count, pending_normals, kept_seen, swap_seen, degen_seen;
  int              sent_count;
  logic [31:0]     cur_feature;
  bit              calm;   // true during the stretch with no idling

  oriented_triangle_unit_normal_top u_dut (
    .clk_i, .rst_ni, .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .m_axis_tvalid, .m_axis_tready,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  otun_checker u_checker (
    .clk_i, .rst_ni,
    .s_tdata(s_axis_tdata), .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
    .m_tdata(m_axis_tdata), .m_tuser(m_axis_tuser), .m_tvalid(m_axis_tvalid),
    .m_tready(m_axis_tready), .psel, .penable, .pwrite, .paddr, .pwdata,
    .fail_count, .pending_normals, .kept_seen, .swap_seen, .degen_seen
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // The receiver stalls about a third of the time, except in the calm stretch.
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 34);
  end

  // The whole run fits well within this timeout even with every item kept.
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Does an APB write to the given address with a setup and an access cycle.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == 3'd0) cur_feature = data;
  endtask

  // Offers one triangle word and holds it until the block takes it; the valid
  // line stays high when the next word follows at once.
  task automatic send_triangle(input logic [InW-1:0] d);
    if (!calm) begin
      while ($urandom_range(99) < 34) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tdata  <= d;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
  endtask

  // Waits for every expected result, then lets the back end settle.
  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_normals != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      2: return {{16{1'b0}}, 16'($urandom())} ^ {32{1'($urandom_range(1))}};
      default: return $urandom_range(7);
    endcase
  endfunction

  // Builds a triangle whose labels match the target as requested.
  function automatic logic [InW-1:0] make_triangle(input int sel, input int mode);
    logic [InW-1:0] d;
    logic [31:0]    other;
    for (int i = 0; i < 9; i++) d[32*i +: 32] = rand_coord(mode);
    other = $urandom();
    if (other == cur_feature) other = ~other;
    case (sel)
      0: begin d[32*9 +: 32] = cur_feature; d[32*10 +: 32] = other; end
      1: begin d[32*9 +: 32] = other; d[32*10 +: 32] = cur_feature; end
      2: begin d[32*9 +: 32] = cur_feature; d[32*10 +: 32] = cur_feature; end
      default: begin d[32*9 +: 32] = other; d[32*10 +: 32] = $urandom(); end
    endcase
    return d;
  endfunction

  initial begin
    logic [InW-1:0] d;
    logic [31:0]    feats [4];
    int             r;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    calm          = 1'b0;
    sent_count    = 0;
    cur_feature   = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the reset target of zero.
    d = '0;
    send_triangle(d);                         // all zero: degenerate, kept
    d = make_triangle(0, 1); send_triangle(d);
    d = make_triangle(1, 1); send_triangle(d);   // back match swaps
    d = make_triangle(2, 1); send_triangle(d);   // both match: front wins
    d = make_triangle(3, 1); send_triangle(d);   // dropped
    // Extreme corners give the widest cross product.
    d = '0;
    d[0 +: 32] = 32'h8000_0000; d[32 +: 32] = 32'h8000_0000; d[64 +: 32] = 32'h8000_0000;
    d[96 +: 32] = 32'h7FFF_FFFF; d[128 +: 32] = 32'h8000_0000;
    d[160 +: 32] = 32'h8000_0000;
    d[192 +: 32] = 32'h8000_0000; d[224 +: 32] = 32'h7FFF_FFFF;
    d[256 +: 32] = 32'h8000_0000;
    send_triangle(d);
    d[320 +: 32] = 32'h0; d[288 +: 32] = 32'hFFFF_FFFF; send_triangle(d);
    d = {352{1'b1}}; d[288 +: 32] = 32'h0; send_triangle(d);
    // Collinear vertices are degenerate too.
    d = '0;
    d[96 +: 32] = 32'h0001_0000; d[192 +: 32] = 32'h0002_0000;
    send_triangle(d);
    // Tiny triangles need a left shift during normalization.
    d = '0; d[96 +: 32] = 32'd1; d[224 +: 32] = 32'd1; send_triangle(d);
    d = '0; d[96 +: 32] = 32'd1; d[160 +: 32] = 32'd3; d[256 +: 32] = 32'd2;
    send_triangle(d);
    drain();

    feats[0] = 32'h8000_0000;
    feats[1] = 32'h7FFF_FFFF;
    feats[2] = 32'hFFFF_FFFF;
    feats[3] = 32'h0000_0005;
    apb_write(3'd4, 32'h1234_5678);             // unmapped address is ignored
    apb_write(3'd0, feats[0]);
    d = make_triangle(0, 0); send_triangle(d);
    d = make_triangle(1, 0); send_triangle(d);
    d = make_triangle(2, 2); send_triangle(d);
    d = make_triangle(3, 0); send_triangle(d);
    drain();

    // Random part in several phases, each with its own target.
    for (int ph = 0; ph < 6; ph++) begin
      apb_write(3'd0, ph < 4 ? feats[ph] : $urandom());
      calm = (ph == 2);
      for (int n = 0; n < 220; n++) begin
        r = $urandom_range(99);
        d = make_triangle(r < 45 ? 0 : r < 80 ? 1 : r < 88 ? 2 : 3,
                          $urandom_range(3));
        send_triangle(d);
        // Hold the sender until every result is out, once per phase.
        if (n == 100) begin
          s_axis_tvalid <= 1'b0;
          do @(posedge clk_i); while (pending_normals != 0);
        end
      end
      calm = 1'b0;
      drain();
    end

    $display("Sent %0d triangles over 8 target settings; %0d normals checked,",
             sent_count, kept_seen);
    $display("  %0d of them with swapped winding and %0d degenerate.",
             swap_seen, degen_seen);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
